FILE: rtl/md5_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 package
// Shared types, constants and round tables for the MD5 digest engine.
// ----------------------------------------------------------------------------
package md5_pkg;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hEFCDAB89;
  localparam logic [31:0] InitC = 32'h98BADCFE;
  localparam logic [31:0] InitD = 32'h10325476;
  localparam logic [7:0]  PadByte = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_ADD,
    ST_PAD,
    ST_OUT
  } md5_state_e;

  typedef struct packed {
    logic       start;
    logic [5:0] step;
  } md5_rnd_ctl_t;

  function automatic logic [31:0] md5_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;
      6'd2: k = 32'h242070db;  6'd3: k = 32'hc1bdceee;
      6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;
      6'd8: k = 32'h698098d8;  6'd9: k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb; default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] md5_rot(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'h0: s = 5'd7;  4'h1: s = 5'd12; 4'h2: s = 5'd17; 4'h3: s = 5'd22;
      4'h4: s = 5'd5;  4'h5: s = 5'd9;  4'h6: s = 5'd14; 4'h7: s = 5'd20;
      4'h8: s = 5'd4;  4'h9: s = 5'd11; 4'hA: s = 5'd16; 4'hB: s = 5'd23;
      4'hC: s = 5'd6;  4'hD: s = 5'd10; 4'hE: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

  function automatic logic [3:0] md5_msg_idx(input logic [5:0] i);
    logic [3:0] g;
    case (i[5:4])
      2'd0: g = i[3:0];
      2'd1: g = 4'(({2'b0, i} << 2) + {2'b0, i} + 8'd1);
      2'd2: g = 4'(({2'b0, i} << 1) + {2'b0, i} + 8'd5);
      default: g = 4'(({2'b0, i} << 3) - {2'b0, i});
    endcase
    return g;
  endfunction

endpackage

FILE: rtl/md5_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 round unit
// One MD5 step per cycle on the working words; 64 steps per block.
// ----------------------------------------------------------------------------
module md5_round (
  input  logic                  clk_i,
  input  md5_pkg::md5_rnd_ctl_t ctl_i,
  input  logic [127:0]          chain_i,
  input  logic [31:0]           msg_i,
  output logic [3:0]            msg_idx_o,
  output logic [127:0]          work_o
);
  import md5_pkg::*;

  logic [31:0] a_q, b_q, c_q, d_q;
  logic [31:0] a, b, c, d, f, sum, rot;
  logic [4:0]  s;

  always_comb begin
    a = ctl_i.start ? chain_i[31:0]   : a_q;
    b = ctl_i.start ? chain_i[63:32]  : b_q;
    c = ctl_i.start ? chain_i[95:64]  : c_q;
    d = ctl_i.start ? chain_i[127:96] : d_q;
    case (ctl_i.step[5:4])
      2'd0: f = (b & c) | (~b & d);
      2'd1: f = (b & d) | (c & ~d);
      2'd2: f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    s   = md5_rot(ctl_i.step);
    sum = a + f + msg_i + md5_k(ctl_i.step);
    rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
  end

  assign msg_idx_o = md5_msg_idx(ctl_i.step);
  assign work_o    = {d_q, c_q, b_q, a_q};

  always_ff @(posedge clk_i) begin
    a_q <= d;
    b_q <= b + rot;
    c_q <= b;
    d_q <= c;
  end

endmodule

FILE: rtl/md5_digest_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 digest engine
// Streaming MD5: bytes in, four little-endian digest words out per message.
// ----------------------------------------------------------------------------
// Channel | Direction | Signals
// in      | in        | in_valid_i/in_ready_o, data_byte_i, byte_present_i, last_byte_i
// out     | out       | out_valid_o/out_ready_i, digest_word_o, word_index_o, last_word_o
// Bytes are taken in the idle state; the 64th byte of a block starts 64 rounds
// through the shared round unit followed by one add into the chaining words.
// Closing a message: 1 or 2 padded blocks, each a pad step, the rounds and the
// add, then 4 output words. Not ready while a block compresses or the digest
// drains. Reset is async.
// ----------------------------------------------------------------------------
module md5_digest_engine_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        byte_present_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [1:0]  word_index_o,
  output logic        last_word_o
);
  import md5_pkg::*;

  md5_state_e   state_q, state_d;
  logic [31:0]  buf_q [16];
  logic [127:0] chain_q;
  logic [63:0]  cnt_q;
  logic [5:0]   step_q;
  logic         closing_q;   // message is being closed
  logic         final_q;     // current block is the length block
  logic         padded_q;    // 0x80 already placed
  logic [1:0]   oidx_q;
  logic         acc;
  logic [5:0]   pos;
  logic [3:0]   midx;
  logic [127:0] work;
  md5_rnd_ctl_t ctl;

  assign acc = in_valid_i && in_ready_o;
  assign pos = cnt_q[5:0];
  assign ctl.start = (step_q == 6'd0);
  assign ctl.step  = step_q;

  md5_round u_round (
    .clk_i    (clk_i),
    .ctl_i    (ctl),
    .chain_i  (chain_q),
    .msg_i    (buf_q[midx]),
    .msg_idx_o(midx),
    .work_o   (work)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          if (byte_present_i && pos == 6'd63) state_d = ST_ROUND;
          else if (last_byte_i) state_d = ST_PAD;
        end
      end
      ST_ROUND: if (step_q == 6'd63) state_d = ST_ADD;
      ST_ADD: begin
        if (final_q) state_d = ST_OUT;
        else if (closing_q) state_d = ST_PAD;
        else state_d = ST_IDLE;
      end
      ST_PAD: state_d = ST_ROUND;
      ST_OUT: if (out_ready_i && oidx_q == 2'd3) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o    = (state_q == ST_IDLE);
    out_valid_o   = (state_q == ST_OUT);
    digest_word_o = chain_q[{oidx_q, 5'd0} +: 32];
    word_index_o  = oidx_q;
    last_word_o   = (oidx_q == 2'd3);
  end

  // block buffer: byte packing and padding
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && acc && byte_present_i) begin
      if (pos[1:0] == 2'd0) buf_q[pos[5:2]] <= {24'd0, data_byte_i};
      else buf_q[pos[5:2]][{pos[1:0], 3'd0} +: 8] <= data_byte_i;
    end else if (state_q == ST_PAD) begin
      for (int w = 0; w < 16; w++) begin
        if (padded_q) begin
          buf_q[w] <= 32'd0;
        end else if (4'(w) == pos[5:2]) begin
          if (pos[1:0] == 2'd0) buf_q[w] <= {24'd0, PadByte};
          else buf_q[w][{pos[1:0], 3'd0} +: 8] <= PadByte;
        end else if (4'(w) > pos[5:2]) begin
          buf_q[w] <= 32'd0;
        end
      end
      if (padded_q || pos < 6'd56) begin
        buf_q[14] <= {cnt_q[28:0], 3'd0};
        buf_q[15] <= cnt_q[60:29];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      chain_q   <= {InitD, InitC, InitB, InitA};
      cnt_q     <= 64'd0;
      step_q    <= 6'd0;
      closing_q <= 1'b0;
      final_q   <= 1'b0;
      padded_q  <= 1'b0;
      oidx_q    <= 2'd0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        ST_IDLE: begin
          if (acc) begin
            if (byte_present_i) cnt_q <= cnt_q + 64'd1;
            closing_q <= last_byte_i;
          end
        end
        ST_ROUND: step_q <= step_q + 6'd1;
        ST_ADD: begin
          for (int i = 0; i < 4; i++) begin
            chain_q[i*32 +: 32] <= chain_q[i*32 +: 32] + work[i*32 +: 32];
          end
        end
        ST_PAD: begin
          final_q  <= padded_q || pos < 6'd56;
          padded_q <= 1'b1;
        end
        ST_OUT: begin
          if (out_ready_i) begin
            oidx_q <= oidx_q + 2'd1;
            if (oidx_q == 2'd3) begin
              chain_q   <= {InitD, InitC, InitB, InitA};
              cnt_q     <= 64'd0;
              closing_q <= 1'b0;
              final_q   <= 1'b0;
              padded_q  <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_round_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_ROUND && step_q == 6'd63 |=> state_q == ST_ADD)
    else $error("round count did not end in add");
  a_step_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_ROUND |-> step_q == 6'd0)
    else $error("step counter not zero outside rounds");
  a_out_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_OUT |-> final_q && closing_q)
    else $error("digest without closed message");
  a_out_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_word_o |=> state_q == ST_IDLE && cnt_q == 64'd0)
    else $error("engine not reset after digest");
`endif

endmodule

FILE: tb/tb_md5_digest_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MD5 digest engine testbench
// Streams messages of directed and random lengths into the engine with random
// idles on both sides and one long output hold-off. A behavioral MD5 model
// predicts the four digest words of each message; results are checked in order.
// ----------------------------------------------------------------------------
module tb_md5_digest_engine_top;

  typedef struct packed {
    logic [7:0] data;
    logic       present;
    logic       last;
  } byte_req_t;

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  idx;
    logic        last;
  } digest_req_t;

  localparam int unsigned IdleLimit = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  data_byte_i;
  logic        byte_present_i;
  logic        last_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] digest_word_o;
  logic [1:0]  word_index_o;
  logic        last_word_o;

  byte_req_t   pending_q[$];
  digest_req_t digest_q[$];

  logic [31:0] hash_st[4];
  logic [31:0] msg_blk[16];
  logic [63:0] msg_len;

  int unsigned err_cnt;
  int unsigned quiet_cnt;
  int unsigned hold_cnt;
  logic        calm;
  logic        stim_done;

  md5_digest_engine_top u_top (.*);

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic logic [31:0] rnd_const(input int unsigned i);
    return 32'(longint'($floor(((2.0 ** 32)) * ($sin(real'(i + 1)) < 0 ?
                                 -$sin(real'(i + 1)) : $sin(real'(i + 1))))));
  endfunction

  task automatic hash_block();
    logic [31:0] a, b, c, d, f, t;
    int unsigned g, r, s;
    int unsigned shifts[16];
    shifts = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    a = hash_st[0];
    b = hash_st[1];
    c = hash_st[2];
    d = hash_st[3];
    for (int i = 0; i < 64; i++) begin
      r = i / 16;
      case (r)
        0: begin
          f = (b & c) | (~b & d);
          g = i;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = 1 + 5 * i;
        end
        2: begin
          f = b ^ c ^ d;
          g = 5 + 3 * i;
        end
        default: begin
          f = c ^ (b | ~d);
          g = 7 * i;
        end
      endcase
      s = shifts[r * 4 + i % 4];
      t = a + f + msg_blk[g % 16] + rnd_const(i);
      t = (t << s) | (t >> (32 - s));
      a = d;
      d = c;
      c = b;
      b = b + t;
    end
    hash_st[0] += a;
    hash_st[1] += b;
    hash_st[2] += c;
    hash_st[3] += d;
  endtask

  task automatic clear_digest();
    hash_st = '{32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476};
    msg_blk = '{default: '0};
    msg_len = '0;
  endtask

  task automatic store_byte(input logic [5:0] pos, input logic [7:0] v);
    if (pos[1:0] == 2'd0) msg_blk[pos[5:2]] = {24'd0, v};
    else msg_blk[pos[5:2]] |= 32'(v) << (8 * pos[1:0]);
  endtask

  task automatic predict_digest(input byte_req_t req);
    logic [5:0]  pos;
    logic [63:0] bits;
    if (req.present) begin
      pos = msg_len[5:0];
      store_byte(pos, req.data);
      msg_len++;
      if (pos == 6'd63) hash_block();
    end
    if (req.last) begin
      pos = msg_len[5:0];
      store_byte(pos, 8'h80);
      for (int w = pos[5:2] + 1; w < 16; w++) msg_blk[w] = '0;
      if (pos >= 6'd56) begin
        hash_block();
        msg_blk = '{default: '0};
      end
      bits = msg_len << 3;
      msg_blk[14] = bits[31:0];
      msg_blk[15] = bits[63:32];
      hash_block();
      for (int i = 0; i < 4; i++) digest_q.push_back({hash_st[i], 2'(i), i == 3});
      clear_digest();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $time);
    err_cnt++;
  endtask

  task automatic add_msg(input int unsigned len, input bit noise);
    for (int i = 0; i < len; i++) begin
      if (noise && $urandom_range(0, 9) == 0)
        pending_q.push_back({8'($urandom), 1'b0, 1'b0});
      pending_q.push_back({8'($urandom), 1'b1, i == len - 1});
    end
    if (len == 0) pending_q.push_back({8'($urandom), 1'b0, 1'b1});
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      data_byte_i    <= '0;
      byte_present_i <= 1'b0;
      last_byte_i    <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) predict_digest({data_byte_i, byte_present_i, last_byte_i});
      if (pending_q.size() > 0 && (calm || $urandom_range(0, 99) >= 32)) begin
        {data_byte_i, byte_present_i, last_byte_i} <= pending_q.pop_front();
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt    <= hold_cnt - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || $urandom_range(0, 99) >= 32;
    end
  end

  always @(posedge clk_i) begin
    digest_req_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (digest_q.size() == 0) begin
        report_mismatch("unexpected word", digest_word_o, '0);
      end else begin
        want = digest_q.pop_front();
        if (digest_word_o !== want.word) report_mismatch("digest_word", digest_word_o, want.word);
        if (word_index_o !== want.idx) report_mismatch("word_index", 32'(word_index_o), 32'(want.idx));
        if (last_word_o !== want.last) report_mismatch("last_word", 32'(last_word_o), 32'(want.last));
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || !rst_ni) quiet_cnt <= 0;
    else quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt >= IdleLimit) begin
      $display("md5_digest_engine_top test failed");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    err_cnt   = 0;
    quiet_cnt = 0;
    hold_cnt  = 0;
    calm      = 1'b0;
    stim_done = 1'b0;
    rst_ni    = 1'b0;
    clear_digest();
    add_msg(0, 0);
    pending_q.push_back({8'hff, 1'b0, 1'b0});
    pending_q.push_back({8'h00, 1'b1, 1'b1});
    pending_q.push_back({8'hff, 1'b1, 1'b0});
    pending_q.push_back({8'h00, 1'b0, 1'b1});
    add_msg(3, 0);
    add_msg(57, 0);
    for (int m = 0; m < 6; m++) begin
      n = $urandom_range(0, 12);
      add_msg(n, 1);
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    hold_cnt = 400;
    wait (pending_q.size() < 70);
    calm = 1'b1;
    wait (pending_q.size() < 35);
    calm = 1'b0;
    wait (pending_q.size() == 0);
    @(posedge clk_i);
    wait (!in_valid_i);
    wait (digest_q.size() == 0);
    repeat (200) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("md5_digest_engine_top test passed");
    end else begin
      $display("md5_digest_engine_top test failed");
    end
    $finish;
  end

endmodule

FILE: md5_digest_engine_top.f
rtl/md5_pkg.sv
rtl/md5_round.sv
rtl/md5_digest_engine_top.sv
tb/tb_md5_digest_engine_top.sv
